>>> hdl/rts_pkg.sv
// Package for the recovery trigger supervisor: types, event codes, register
// indexes and reset values. No dependencies.
`default_nettype none

package rts_pkg;

   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned MS_CFG_W  = 20;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 20;

   localparam logic [COUNT_W-1:0]  COUNT_MAX         = 8'd255;
   localparam logic [COUNT_W-1:0]  THRESHOLD_DEFAULT = 8'd1;
   localparam logic [MS_CFG_W-1:0] COOLDOWN_DEFAULT  = 20'd0;
   localparam logic [MS_CFG_W-1:0] WINDOW_DEFAULT    = 20'd500;

   // Event codes; codes above ACT_RESET behave like a query.
   typedef enum logic [2:0] {
      ACT_FAILURE  = 3'd0,
      ACT_SUCCESS  = 3'd1,
      ACT_FINISHED = 3'd2,
      ACT_QUERY    = 3'd3,
      ACT_RESET    = 3'd4
   } action_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_MS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS   = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0]  trip_level;
      logic [MS_CFG_W-1:0] cooldown_ms;
      logic [MS_CFG_W-1:0] window_ms;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] fail_count;
      logic               active;
      logic [TIME_W-1:0]  start_time;
      logic               start_known;
      logic [TIME_W-1:0]  end_time;
      logic               end_known;
   } sup_state_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [TIME_W-1:0] now_ms;
      logic              recovery_succeeded;
   } event_type;

   typedef struct packed {
      logic               start_recovery;
      logic               recovery_active;
      logic               in_recovery;
      logic [COUNT_W-1:0] failure_count;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/recovery_trigger_supervisor_core.sv
// Top level of the recovery trigger supervisor: input register, state,
// result register. Depends on rts_pkg, rts_csr and rts_eval.
//
// Usage:
//  - req_* is the event channel (valid/ready). Each accepted transaction is
//    one event: action code, timestamp in ms and the recovery success flag.
//  - rsp_* is the result channel (valid/ready). Exactly one result
//    transaction per event, in order.
//  - csr_* writes the threshold, cooldown or window register, one per write;
//    write only while no event is in flight.
// Pipeline: an accepted event is held in the event register, then moves to
//  the result register and is presented on rsp_* (two register stages).
// Throughput: one event per cycle while rsp_ready stays high; the state
//  update is a single compare/add pass between event and result registers.
// Stall: when rsp_ready is low the result register holds, the event register
//  holds its pending event, and req_ready drops only once both are full.
// Reset: synchronous; clears the counter, the active flag, the stored times
//  and their valid bits, and loads the register defaults (threshold 1,
//  cooldown 0, window 500 ms). Both channels come up empty.
`default_nettype none

module recovery_trigger_supervisor_core
   import rts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // event channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_action,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic                 req_recovery_succeeded,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_start_recovery,
   output logic                      rsp_recovery_active,
   output logic                      rsp_in_recovery,
   output logic [COUNT_W-1:0]        rsp_failure_count,
   // configuration
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type       cfg;
   event_type     evt_ff, evt_in;
   logic          evt_valid_ff, evt_valid_in;
   sup_state_type state_ff, state_in;
   sup_state_type state_nxt;
   result_type    res_ff, res_in;
   result_type    res_nxt;
   logic          res_valid_ff, res_valid_in;
   logic          res_free;   // result register can take a new transaction
   logic          evt_move;   // event register retires into result register
   logic          req_take;

   rts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rts_eval u_eval (
      .cfg (cfg),
      .cur (state_ff),
      .evt (evt_ff),
      .nxt (state_nxt),
      .res (res_nxt)
   );

   // handshake: the event stage drains whenever the result stage is free
   assign res_free  = !res_valid_ff || rsp_ready;
   assign evt_move  = evt_valid_ff && res_free;
   assign req_ready = !evt_valid_ff || res_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      evt_valid_in = evt_valid_ff;
      evt_in       = evt_ff;
      if (req_take) begin
         evt_valid_in              = 1'b1;
         evt_in.action             = req_action;
         evt_in.now_ms             = req_now_ms;
         evt_in.recovery_succeeded = req_recovery_succeeded;
      end else if (evt_move) begin
         evt_valid_in = 1'b0;
      end

      // state commits exactly when the event retires
      state_in = evt_move ? state_nxt : state_ff;

      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      if (evt_move) begin
         res_valid_in = 1'b1;
         res_in       = res_nxt;
      end else if (rsp_ready) begin
         res_valid_in = 1'b0;
      end
   end

   // control and supervisor state
   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         res_valid_ff <= res_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
      res_ff <= res_in;
   end

   assign rsp_valid           = res_valid_ff;
   assign rsp_start_recovery  = res_ff.start_recovery;
   assign rsp_recovery_active = res_ff.recovery_active;
   assign rsp_in_recovery     = res_ff.in_recovery;
   assign rsp_failure_count   = res_ff.failure_count;

   // a start always leaves the block active
   a_start_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_recovery |-> rsp_recovery_active)
      else $error("start reported without active flag");

   // in-recovery needs the active flag
   a_inrec_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_recovery |-> rsp_recovery_active)
      else $error("in_recovery without active flag");

   // a start comes from a counted failure
   a_start_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_recovery |-> rsp_failure_count != '0)
      else $error("start with zero failure count");

   // a retired event always produces a result
   a_res_source: assert property (@(posedge clock) disable iff (reset)
      evt_move |=> res_valid_ff)
      else $error("retired event produced no result");

   // state changes only when an event retires
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !evt_move |=> $stable(state_ff))
      else $error("state changed without an event");

endmodule

`default_nettype wire

>>> hdl/rts_csr.sv
// Configuration registers of the recovery trigger supervisor.
// Depends on rts_pkg.
`default_nettype none

module rts_csr
   import rts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRIP_LEVEL:  cfg_in.trip_level  = csr_wdata[COUNT_W-1:0];
            CSR_COOLDOWN_MS: cfg_in.cooldown_ms = csr_wdata[MS_CFG_W-1:0];
            CSR_WINDOW_MS:   cfg_in.window_ms   = csr_wdata[MS_CFG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_level  <= THRESHOLD_DEFAULT;
         cfg_ff.cooldown_ms <= COOLDOWN_DEFAULT;
         cfg_ff.window_ms   <= WINDOW_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/rts_eval.sv
// Event evaluation: next supervisor state and the result for one event.
// Purely combinational. Depends on rts_pkg.
`default_nettype none

module rts_eval
   import rts_pkg::*;
(
   input  wire cfg_type       cfg,
   input  wire sup_state_type cur,
   input  wire event_type     evt,
   output sup_state_type      nxt,
   output result_type         res
);

   logic [COUNT_W-1:0]  thr_eff;
   logic [MS_CFG_W-1:0] win_eff;
   logic [COUNT_W-1:0]  count_inc;
   logic [TIME_W-1:0]   since_end;
   logic [TIME_W-1:0]   since_start;
   logic                cooldown_ok;
   logic                may_start;

   always_comb begin
      // zero in a register means the default
      thr_eff   = (cfg.trip_level == '0) ? THRESHOLD_DEFAULT : cfg.trip_level;
      win_eff   = (cfg.window_ms == '0) ? WINDOW_DEFAULT : cfg.window_ms;
      count_inc = (cur.fail_count == COUNT_MAX) ? COUNT_MAX : cur.fail_count + 1'b1;

      since_end   = evt.now_ms - cur.end_time;
      cooldown_ok = !cur.end_known ||
                    ($signed(since_end) >= $signed({12'd0, cfg.cooldown_ms}));
      may_start   = !cur.active && (count_inc >= thr_eff) && cooldown_ok;

      nxt                = cur;
      res.start_recovery = 1'b0;
      case (evt.action)
         ACT_FAILURE: begin
            nxt.fail_count = count_inc;
            if (may_start) begin
               nxt.active         = 1'b1;
               nxt.start_time     = evt.now_ms;
               nxt.start_known    = 1'b1;
               res.start_recovery = 1'b1;
            end
         end
         ACT_SUCCESS: begin
            nxt.fail_count = '0;
         end
         ACT_FINISHED: begin
            nxt.active    = 1'b0;
            nxt.end_time  = evt.now_ms;
            nxt.end_known = 1'b1;
            if (evt.recovery_succeeded) begin
               nxt.fail_count = '0;
            end
         end
         ACT_RESET: begin
            nxt = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase

      // window check on the updated state; a time before the start passes
      since_start         = evt.now_ms - nxt.start_time;
      res.recovery_active = nxt.active;
      res.in_recovery     = nxt.active && nxt.start_known &&
                            ($signed(since_start) <= $signed({12'd0, win_eff}));
      res.failure_count   = nxt.fail_count;
   end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for recovery_trigger_supervisor_core: a directed table, then random
// event phases, checked against a cycle-free shadow of the supervisor.
// Depends on rts_pkg and the core RTL.

module tb;
   import rts_pkg::*;

   // Event codes 5..7 are undefined and answer like a query.
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam int         MAX_REPORTS      = 10;
   localparam int         SETTLE_CYCLES    = 4;   // the core has two register stages
   localparam int         PHASE_ITEMS      = 280;

   // One row of the directed script: either a register write or an event.
   // Events with 'typed' set carry an expectation written by hand.
   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] data;
      logic [2:0]           act;
      logic [TIME_W-1:0]    now;
      logic                 ok;
      logic                 typed;
      result_type           want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_action = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 req_recovery_succeeded = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_start_recovery;
   logic                 rsp_recovery_active;
   logic                 rsp_in_recovery;
   logic [COUNT_W-1:0]   rsp_failure_count;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Shadow copy of the supervisor state and its registers
   logic [COUNT_W-1:0]  shadow_count;
   logic                shadow_active;
   logic [TIME_W-1:0]   shadow_start;
   logic                shadow_start_ok;
   logic [TIME_W-1:0]   shadow_end;
   logic                shadow_end_ok;
   logic [COUNT_W-1:0]  shadow_thr;
   logic [MS_CFG_W-1:0] shadow_cool;
   logic [MS_CFG_W-1:0] shadow_win;

   result_type        verdict_q[$];   // expected results, oldest first
   row_type           script[$];
   int                sent = 0;
   int                mismatch_total = 0;
   int                send_idle_pct = 9;
   int                recv_idle_pct = 54;
   logic [TIME_W-1:0] clk_ms = '0;    // running time base for the random part

   recovery_trigger_supervisor_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_now_ms             (req_now_ms),
      .req_recovery_succeeded (req_recovery_succeeded),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_start_recovery     (rsp_start_recovery),
      .rsp_recovery_active    (rsp_recovery_active),
      .rsp_in_recovery        (rsp_in_recovery),
      .rsp_failure_count      (rsp_failure_count),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one event to the shadow state and returns the result the core
   // must produce for it. Time differences wrap at 32 bits and read signed.
   function automatic result_type supervise_event(input logic [2:0] act,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic ok);
      result_type   r;
      int           since;
      int           cool_gap;
      int           span;
      logic [7:0]   need;
      r        = '0;
      cool_gap = int'(shadow_cool);
      span     = (shadow_win == '0) ? int'(WINDOW_DEFAULT) : int'(shadow_win);
      need     = (shadow_thr == '0) ? 8'd1 : shadow_thr;
      case (act)
         ACT_FAILURE: begin
            if (shadow_count != COUNT_MAX)
               shadow_count = shadow_count + 8'd1;
            since = $signed(now - shadow_end);
            // new count is compared; a recorded end gates on the cooldown
            if (!shadow_active && shadow_count >= need &&
                (!shadow_end_ok || since >= cool_gap)) begin
               shadow_active   = 1'b1;
               shadow_start    = now;
               shadow_start_ok = 1'b1;
               r.start_recovery = 1'b1;
            end
         end
         ACT_SUCCESS: begin
            shadow_count = '0;
         end
         ACT_FINISHED: begin
            shadow_active = 1'b0;
            shadow_end    = now;
            shadow_end_ok = 1'b1;
            if (ok)
               shadow_count = '0;
         end
         ACT_RESET: begin
            shadow_count    = '0;
            shadow_active   = 1'b0;
            shadow_start    = '0;
            shadow_start_ok = 1'b0;
            shadow_end      = '0;
            shadow_end_ok   = 1'b0;
         end
         default: begin
         end
      endcase
      // window check after the update; a time before the start passes
      since = $signed(now - shadow_start);
      r.recovery_active = shadow_active;
      r.in_recovery     = shadow_active && shadow_start_ok && (since <= span);
      r.failure_count   = shadow_count;
      return r;
   endfunction

   function automatic row_type ev_row(input logic [2:0] act, input logic [TIME_W-1:0] now,
                                      input logic ok);
      row_type r;
      r     = '0;
      r.act = act;
      r.now = now;
      r.ok  = ok;
      return r;
   endfunction

   function automatic row_type checked_row(input logic [2:0] act,
                                           input logic [TIME_W-1:0] now,
                                           input logic ok, input result_type want);
      row_type r;
      r       = ev_row(act, now, ok);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DAT_W-1:0] data);
      row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.data   = data;
      return r;
   endfunction

   // Sends one event transaction and records its expectation at acceptance.
   // Valid stays high into the next call unless an idle stretch is drawn.
   task automatic issue(input logic [2:0] act, input logic [TIME_W-1:0] now,
                        input logic ok, input logic typed, input result_type want);
      result_type predicted;
      req_valid              <= 1'b1;
      req_action             <= act;
      req_now_ms             <= now;
      req_recovery_succeeded <= ok;
      do @(posedge clock); while (!req_ready);
      predicted = supervise_event(act, now, ok);
      verdict_q.push_back(typed ? want : predicted);
      sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Stops sending until every expected result has come back, plus the
   // pipeline depth, so the core is idle afterwards.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TRIP_LEVEL:  shadow_thr  = data[COUNT_W-1:0];
         CSR_COOLDOWN_MS: shadow_cool = data[MS_CFG_W-1:0];
         CSR_WINDOW_MS:   shadow_win  = data[MS_CFG_W-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Random traffic: mostly failure streaks that start near the cooldown edge and
   // often reach the threshold, each with queries near the window edge and often a
   // finish; the rest is successes, resets, one drain pause now and then, and raw noise.
   task automatic random_phase(input int items);
      int                target;
      int                len;
      int                k;
      int                pick;
      int                need;
      int                span;
      target = sent + items;
      while (sent < target) begin
         need = (shadow_thr == '0) ? 1 : int'(shadow_thr);
         span = (shadow_win == '0) ? int'(WINDOW_DEFAULT) : int'(shadow_win);
         pick = $urandom_range(99);
         if (pick < 60) begin
            if ($urandom_range(1) == 1)
               clk_ms = clk_ms + 32'(shadow_cool) + 32'($urandom_range(2)) - 32'd1;
            else
               clk_ms = clk_ms + 32'($urandom_range(int'(shadow_cool) * 2 + 10));
            if ($urandom_range(3) == 0)
               len = $urandom_range(need, 1);
            else
               len = need + $urandom_range(3);
            for (k = 0; k < len; k++) begin
               issue(ACT_FAILURE, clk_ms, 1'($urandom_range(1)), 1'b0, '0);
               clk_ms = clk_ms + 32'($urandom_range(2));
            end
            repeat ($urandom_range(3, 1)) begin
               if ($urandom_range(1) == 1)
                  clk_ms = shadow_start + 32'(span) + 32'($urandom_range(2)) - 32'd1;
               else
                  clk_ms = clk_ms + 32'($urandom_range(span));
               issue(ACT_QUERY, clk_ms, 1'($urandom_range(1)), 1'b0, '0);
            end
            if ($urandom_range(3) != 0) begin
               clk_ms = clk_ms + 32'($urandom_range(span));
               issue(ACT_FINISHED, clk_ms, 1'($urandom_range(1)), 1'b0, '0);
            end
         end else if (pick < 72) begin
            clk_ms = clk_ms + 32'($urandom_range(50));
            issue(ACT_SUCCESS, clk_ms, 1'($urandom_range(1)), 1'b0, '0);
         end else if (pick < 75) begin
            issue(ACT_RESET, clk_ms, 1'($urandom_range(1)), 1'b0, '0);
         end else if (pick < 76) begin
            settle();
         end else begin
            case ($urandom_range(2))
               0:       clk_ms = $urandom;
               1:       clk_ms = clk_ms - 32'($urandom_range(1000));
               default: clk_ms = clk_ms + 32'($urandom_range(1000));
            endcase
            issue(3'($urandom_range(ACT_UNUSED_LAST)), clk_ms, 1'($urandom_range(1)),
                  1'b0, '0);
         end
      end
   endtask

   task automatic note_mismatch(input string what, input result_type want,
                                input result_type got);
      if (mismatch_total < MAX_REPORTS) begin
         $write("%0t %s: exp start=%0b active=%0b in=%0b count=%0d, ",
                $realtime, what, want.start_recovery, want.recovery_active,
                want.in_recovery, want.failure_count);
         $display("got start=%0b active=%0b in=%0b count=%0d",
                  got.start_recovery, got.recovery_active, got.in_recovery,
                  got.failure_count);
      end
      mismatch_total++;
   endtask

   // Result side: check each accepted transaction, then draw the next ready.
   always @(posedge clock) begin : collect
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.start_recovery  = rsp_start_recovery;
         got.recovery_active = rsp_recovery_active;
         got.in_recovery     = rsp_in_recovery;
         got.failure_count   = rsp_failure_count;
         if (verdict_q.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = verdict_q.pop_front();
            if (got.start_recovery !== want.start_recovery ||
                got.recovery_active !== want.recovery_active ||
                got.in_recovery !== want.in_recovery ||
                got.failure_count !== want.failure_count)
               note_mismatch("result mismatch", want, got);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase;

      // Shadow starts from the reset values of state and registers.
      shadow_count    = '0;
      shadow_active   = 1'b0;
      shadow_start    = '0;
      shadow_start_ok = 1'b0;
      shadow_end      = '0;
      shadow_end_ok   = 1'b0;
      shadow_thr      = THRESHOLD_DEFAULT;
      shadow_cool     = COOLDOWN_DEFAULT;
      shadow_win      = WINDOW_DEFAULT;

      // Directed script under reset defaults: threshold 1, cooldown 0, window 500.
      script.push_back(checked_row(ACT_QUERY,    32'd0,   1'b0, {1'b0, 1'b0, 1'b0, 8'd0}));
      script.push_back(checked_row(ACT_FAILURE,  32'd100, 1'b0, {1'b1, 1'b1, 1'b1, 8'd1}));
      // window edge: exactly 500 ms after start is still in recovery
      script.push_back(checked_row(ACT_QUERY,    32'd600, 1'b0, {1'b0, 1'b1, 1'b1, 8'd1}));
      script.push_back(checked_row(ACT_QUERY,    32'd601, 1'b0, {1'b0, 1'b1, 1'b0, 8'd1}));
      // time before the start passes the window check
      script.push_back(checked_row(ACT_QUERY,    32'd99,  1'b0, {1'b0, 1'b1, 1'b1, 8'd1}));
      script.push_back(ev_row(ACT_FAILURE,  32'd700, 1'b0));
      script.push_back(ev_row(ACT_FINISHED, 32'd800, 1'b0));
      // time before the recorded end fails the cooldown even at cooldown 0
      script.push_back(ev_row(ACT_FAILURE,  32'd799, 1'b0));
      script.push_back(ev_row(ACT_FAILURE,  32'd800, 1'b0));
      script.push_back(ev_row(ACT_SUCCESS,  32'd801, 1'b1));
      script.push_back(ev_row(ACT_FINISHED, 32'd802, 1'b1));
      script.push_back(checked_row(ACT_UNUSED_FIRST, 32'hFFFF_FFFF, 1'b1,
                                   {1'b0, 1'b0, 1'b0, 8'd0}));
      script.push_back(checked_row(ACT_UNUSED_LAST, 32'd0, 1'b0, {1'b0, 1'b0, 1'b0, 8'd0}));
      // success flag on a failure is ignored; far-off time reads as before the end
      script.push_back(checked_row(ACT_FAILURE, 32'hFFFF_FFFF, 1'b1,
                                   {1'b0, 1'b0, 1'b0, 8'd1}));
      script.push_back(checked_row(ACT_RESET,   32'd0, 1'b0, {1'b0, 1'b0, 1'b0, 8'd0}));
      // start at the top of the time range; the window wraps through zero
      script.push_back(checked_row(ACT_FAILURE, 32'hFFFF_FFFF, 1'b0,
                                   {1'b1, 1'b1, 1'b1, 8'd1}));
      script.push_back(checked_row(ACT_QUERY,   32'd499, 1'b0, {1'b0, 1'b1, 1'b1, 8'd1}));
      script.push_back(checked_row(ACT_QUERY,   32'd500, 1'b0, {1'b0, 1'b1, 1'b0, 8'd1}));
      script.push_back(checked_row(ACT_SUCCESS, 32'd0,   1'b1, {1'b0, 1'b1, 1'b1, 8'd0}));
      script.push_back(checked_row(ACT_RESET,   32'd12345, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0}));
      // zero threshold acts as 1, zero window as 500, cooldown above range as written
      script.push_back(csr_row(CSR_TRIP_LEVEL,  20'd0));
      script.push_back(csr_row(CSR_WINDOW_MS,   20'd0));
      script.push_back(csr_row(CSR_COOLDOWN_MS, 20'hF_FFFF));
      script.push_back(ev_row(ACT_FAILURE,  32'd1000, 1'b0));
      script.push_back(ev_row(ACT_FINISHED, 32'd2000, 1'b0));
      script.push_back(ev_row(ACT_FAILURE,  32'd2000 + 32'd1048574, 1'b0));
      script.push_back(ev_row(ACT_FAILURE,  32'd2000 + 32'd1048575, 1'b0));
      script.push_back(ev_row(ACT_QUERY,    32'd2000 + 32'd1048575 + 32'd501, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            write_register(script[i].idx, script[i].data);
         end else begin
            issue(script[i].act, script[i].now, script[i].ok, script[i].typed,
                  script[i].want);
         end
      end

      // Random phases; each one drains the core, then reprograms all registers.
      for (phase = 0; phase < 6; phase++) begin
         settle();
         send_idle_pct = (phase < 2) ? 9 : (phase < 4) ? 54 : 0;
         recv_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 9 : 0;
         case (phase)
            0: begin
               write_register(CSR_TRIP_LEVEL,  20'd3);
               write_register(CSR_COOLDOWN_MS, 20'd200);
               write_register(CSR_WINDOW_MS,   20'd300);
            end
            1: begin
               // maximum threshold drives the count into saturation
               write_register(CSR_TRIP_LEVEL,  20'(COUNT_MAX));
               write_register(CSR_COOLDOWN_MS, 20'd0);
               write_register(CSR_WINDOW_MS,   20'd1);
            end
            2: begin
               write_register(CSR_TRIP_LEVEL,  20'd1);
               write_register(CSR_COOLDOWN_MS, 20'd1000000);
               write_register(CSR_WINDOW_MS,   20'd1000000);
            end
            3: begin
               write_register(CSR_TRIP_LEVEL,  20'd0);
               write_register(CSR_COOLDOWN_MS, 20'hF_FFFF);
               write_register(CSR_WINDOW_MS,   20'd0);
            end
            4: begin
               write_register(CSR_TRIP_LEVEL,  20'($urandom_range(6, 1)));
               write_register(CSR_COOLDOWN_MS, 20'($urandom_range(3000)));
               write_register(CSR_WINDOW_MS,   20'($urandom_range(3000, 1)));
            end
            default: begin
               write_register(CSR_TRIP_LEVEL,  20'($urandom_range(12)));
               write_register(CSR_COOLDOWN_MS, 20'($urandom_range(20'hF_FFFF)));
               write_register(CSR_WINDOW_MS,   20'($urandom_range(20'hF_FFFF)));
            end
         endcase
         random_phase(PHASE_ITEMS);
      end

      settle();
      if (mismatch_total == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> recovery_trigger_supervisor_core.f
hdl/rts_pkg.sv
hdl/rts_csr.sv
hdl/rts_eval.sv
hdl/recovery_trigger_supervisor_core.sv
bench/tb.sv
